[hw/rtl/prc_pkg.sv]
// prc_pkg: widths, constants, the item record passed along the rotation chain
// and the arctangent table for the point-rotate-about-center block
// no dependencies
package prc_pkg;

   // coordinate and register widths
   localparam int COORD_W = 32;
   localparam int ANGLE_W = 16;
   localparam int EXT_W = ANGLE_W + 1;
   localparam int DIFF_W = COORD_W + 1;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 3;

   // rotation chain
   localparam int ITER_DEF = 24;
   localparam int ITER_MAX = 32;
   localparam int IDX_W = $clog2(ITER_MAX);
   localparam int CW = 34;
   localparam int FRAC = 30;
   localparam longint GAIN_Q30 = 652032874;
   localparam longint ONE_Q30 = 1073741824;

   // angle in 1/64 degree
   localparam logic signed [EXT_W-1:0] ANG_FULL = 17'sd23040;
   localparam logic signed [EXT_W-1:0] ANG_HALF = 17'sd11520;
   localparam logic signed [EXT_W-1:0] ANG_QUARTER = 17'sd5760;

   // degrees to radians: z = mag*K + (mag*K_REM + 5760) / 11520
   localparam int MAG_W = 13;
   localparam int MK_W = 32;
   localparam int W_W = 26;
   localparam int DIV_SHIFT = 8;
   localparam int V_W = W_W - DIV_SHIFT;
   localparam int RECIP_W = 19;
   localparam int PR_W = V_W + RECIP_W;
   localparam int RECIP_SHIFT = 24;
   localparam longint K_RATIO = 292817;
   localparam longint K_REM = 7586;
   localparam longint K_BIAS = 5760;
   localparam longint RECIP_45 = 372828;

   // output arithmetic
   localparam int UNIT_W = 32;
   localparam int PROD_W = DIFF_W + UNIT_W;
   localparam int SUM_W = PROD_W + 1;
   localparam int TQ_W = SUM_W - FRAC;
   localparam int RX_W = TQ_W + 1;

   typedef struct packed {
      logic neg;
      logic signed [CW-1:0] x;
      logic signed [CW-1:0] y;
      logic signed [CW-1:0] z;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic signed [COORD_W-1:0] cx;
      logic signed [COORD_W-1:0] cy;
   } prc_lane_type;

   // atan(2^-i) in radians, q2.30
   function automatic logic signed [CW-1:0] prc_atan(input logic [IDX_W-1:0] idx);
      logic signed [CW-1:0] v;
      case (idx)
         5'd0: v = CW'(843314857);
         5'd1: v = CW'(497837829);
         5'd2: v = CW'(263043837);
         5'd3: v = CW'(133525159);
         5'd4: v = CW'(67021687);
         5'd5: v = CW'(33543516);
         5'd6: v = CW'(16775851);
         5'd7: v = CW'(8388437);
         5'd8: v = CW'(4194283);
         5'd9: v = CW'(2097149);
         5'd10: v = CW'(1048576);
         5'd11: v = CW'(524288);
         5'd12: v = CW'(262144);
         5'd13: v = CW'(131072);
         5'd14: v = CW'(65536);
         5'd15: v = CW'(32768);
         5'd16: v = CW'(16384);
         5'd17: v = CW'(8192);
         5'd18: v = CW'(4096);
         5'd19: v = CW'(2048);
         5'd20: v = CW'(1024);
         5'd21: v = CW'(512);
         5'd22: v = CW'(256);
         5'd23: v = CW'(128);
         5'd24: v = CW'(64);
         5'd25: v = CW'(32);
         5'd26: v = CW'(16);
         5'd27: v = CW'(8);
         5'd28: v = CW'(4);
         5'd29: v = CW'(2);
         5'd30: v = CW'(1);
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/prc_if.sv]
// prc_req_if, prc_rsp_if: valid/ready channels carrying points in and
// rotated points out; depends on prc_pkg
interface prc_req_if;
   import prc_pkg::*;
   logic valid;
   logic ready;
   logic signed [COORD_W-1:0] point_x;
   logic signed [COORD_W-1:0] point_y;
   logic signed [COORD_W-1:0] center_x;
   logic signed [COORD_W-1:0] center_y;
   modport source (output valid, output point_x, output point_y,
                   output center_x, output center_y, input ready);
   modport sink (input valid, input point_x, input point_y,
                 input center_x, input center_y, output ready);
endinterface

interface prc_rsp_if;
   import prc_pkg::*;
   logic valid;
   logic ready;
   logic signed [COORD_W-1:0] rotated_x;
   logic signed [COORD_W-1:0] rotated_y;
   modport source (output valid, output rotated_x, output rotated_y, input ready);
   modport sink (input valid, input rotated_x, input rotated_y, output ready);
endinterface

[hw/rtl/prc_front.sv]
// prc_front: four-stage entry pipe; folds the angle, converts it to radians
// in q2.30 and forms the point-to-center differences; depends on prc_pkg
module prc_front (
   input  logic clock,
   input  logic reset,
   input  logic signed [prc_pkg::ANGLE_W-1:0] rotate_angle,
   input  logic up_valid,
   output logic up_ready,
   input  logic signed [prc_pkg::COORD_W-1:0] point_x,
   input  logic signed [prc_pkg::COORD_W-1:0] point_y,
   input  logic signed [prc_pkg::COORD_W-1:0] center_x,
   input  logic signed [prc_pkg::COORD_W-1:0] center_y,
   output logic down_valid,
   input  logic down_ready,
   output prc_pkg::prc_lane_type down_lane
);
   import prc_pkg::*;

   localparam logic [MK_W-1:0] K_C = MK_W'(K_RATIO);
   localparam logic [W_W-1:0] REM_C = W_W'(K_REM);
   localparam logic [W_W-1:0] BIAS_C = W_W'(K_BIAS);
   localparam logic [PR_W-1:0] RECIP_C = PR_W'(RECIP_45);

   // stage valids and take enables
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic take1, take2, take3, take4;

   // stage 1: folded angle
   logic signed [EXT_W-1:0] ang_ext, wrap, fold, fold_abs;
   logic fneg_in;
   logic [MAG_W-1:0] mag1_ff;
   logic sgn1_ff, fneg1_ff;
   logic signed [DIFF_W-1:0] dx1_ff, dy1_ff;
   logic signed [COORD_W-1:0] cx1_ff, cy1_ff;

   // stage 2: whole and remainder parts of the conversion
   logic [MK_W-1:0] mk2_ff;
   logic [W_W-1:0] w2_ff;
   logic sgn2_ff, fneg2_ff;
   logic signed [DIFF_W-1:0] dx2_ff, dy2_ff;
   logic signed [COORD_W-1:0] cx2_ff, cy2_ff;

   // stage 3: reciprocal product for the divide by 45
   logic [MK_W-1:0] mk3_ff;
   logic [PR_W-1:0] pr3_ff;
   logic sgn3_ff, fneg3_ff;
   logic signed [DIFF_W-1:0] dx3_ff, dy3_ff;
   logic signed [COORD_W-1:0] cx3_ff, cy3_ff;

   // stage 4: chain start
   logic [MK_W-1:0] zmag;
   logic signed [CW-1:0] zpos;
   prc_lane_type lane_in, lane4_ff;

   assign take4 = !v4_ff || down_ready;
   assign take3 = !v3_ff || take4;
   assign take2 = !v2_ff || take3;
   assign take1 = !v1_ff || take2;
   assign up_ready = take1;

   // reduce modulo 360 degrees into [-180, 180), then fold into [-90, 90]
   always_comb begin
      ang_ext = {rotate_angle[ANGLE_W-1], rotate_angle};
      if (ang_ext >= ANG_HALF) begin
         wrap = ang_ext - ANG_FULL;
      end else if (ang_ext < -ANG_HALF) begin
         wrap = ang_ext + ANG_FULL;
      end else begin
         wrap = ang_ext;
      end
      fneg_in = 1'b0;
      if (wrap > ANG_QUARTER) begin
         fold = wrap - ANG_HALF;
         fneg_in = 1'b1;
      end else if (wrap < -ANG_QUARTER) begin
         fold = wrap + ANG_HALF;
         fneg_in = 1'b1;
      end else begin
         fold = wrap;
      end
      fold_abs = fold[EXT_W-1] ? -fold : fold;
   end

   assign zmag = mk3_ff + MK_W'(pr3_ff[PR_W-1:RECIP_SHIFT]);
   assign zpos = $signed(CW'(zmag));

   always_comb begin
      lane_in.neg = fneg3_ff;
      lane_in.x = CW'(GAIN_Q30);
      lane_in.y = '0;
      lane_in.z = sgn3_ff ? -zpos : zpos;
      lane_in.dx = dx3_ff;
      lane_in.dy = dy3_ff;
      lane_in.cx = cx3_ff;
      lane_in.cy = cy3_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (take1) v1_ff <= up_valid;
         if (take2) v2_ff <= v1_ff;
         if (take3) v3_ff <= v2_ff;
         if (take4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take1) begin
         mag1_ff <= fold_abs[MAG_W-1:0];
         sgn1_ff <= fold[EXT_W-1];
         fneg1_ff <= fneg_in;
         dx1_ff <= DIFF_W'(point_x) - DIFF_W'(center_x);
         dy1_ff <= DIFF_W'(point_y) - DIFF_W'(center_y);
         cx1_ff <= center_x;
         cy1_ff <= center_y;
      end
      if (take2) begin
         mk2_ff <= MK_W'(mag1_ff) * K_C;
         w2_ff <= W_W'(mag1_ff) * REM_C + BIAS_C;
         sgn2_ff <= sgn1_ff;
         fneg2_ff <= fneg1_ff;
         dx2_ff <= dx1_ff;
         dy2_ff <= dy1_ff;
         cx2_ff <= cx1_ff;
         cy2_ff <= cy1_ff;
      end
      if (take3) begin
         // divide by 11520 as a shift by 8 then a reciprocal multiply by 1/45
         mk3_ff <= mk2_ff;
         pr3_ff <= PR_W'(w2_ff[W_W-1:DIV_SHIFT]) * RECIP_C;
         sgn3_ff <= sgn2_ff;
         fneg3_ff <= fneg2_ff;
         dx3_ff <= dx2_ff;
         dy3_ff <= dy2_ff;
         cx3_ff <= cx2_ff;
         cy3_ff <= cy2_ff;
      end
      if (take4) begin
         lane4_ff <= lane_in;
      end
   end

   assign down_valid = v4_ff;
   assign down_lane = lane4_ff;

endmodule

[hw/rtl/prc_cordic_cell.sv]
// prc_cordic_cell: one rotation-mode micro-rotation with its own register
// stage; the point data rides along unchanged; depends on prc_pkg
module prc_cordic_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic clock,
   input  logic reset,
   input  logic up_valid,
   output logic up_ready,
   input  prc_pkg::prc_lane_type up_lane,
   output logic down_valid,
   input  logic down_ready,
   output prc_pkg::prc_lane_type down_lane
);
   import prc_pkg::*;

   localparam logic signed [CW-1:0] ATAN = prc_atan(IDX_W'(CELL_INDEX));

   logic take;
   logic valid_ff;
   logic signed [CW-1:0] x_cur, y_cur, z_cur, xs, ys;
   prc_lane_type lane_in, lane_ff;

   assign take = !valid_ff || down_ready;
   assign up_ready = take;

   assign x_cur = up_lane.x;
   assign y_cur = up_lane.y;
   assign z_cur = up_lane.z;
   assign xs = x_cur >>> CELL_INDEX;
   assign ys = y_cur >>> CELL_INDEX;

   always_comb begin
      lane_in = up_lane;
      if (!z_cur[CW-1]) begin
         lane_in.x = x_cur - ys;
         lane_in.y = y_cur + xs;
         lane_in.z = z_cur - ATAN;
      end else begin
         lane_in.x = x_cur + ys;
         lane_in.y = y_cur - xs;
         lane_in.z = z_cur + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (take) begin
         valid_ff <= up_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         lane_ff <= lane_in;
      end
   end

   assign down_valid = valid_ff;
   assign down_lane = lane_ff;

endmodule

[hw/rtl/prc_back.sv]
// prc_back: four-stage exit pipe; clamps sine and cosine, multiplies,
// rounds to q16.16, adds the center back and saturates; depends on prc_pkg
module prc_back (
   input  logic clock,
   input  logic reset,
   input  logic up_valid,
   output logic up_ready,
   input  prc_pkg::prc_lane_type up_lane,
   output logic down_valid,
   input  logic down_ready,
   output logic signed [prc_pkg::COORD_W-1:0] rotated_x,
   output logic signed [prc_pkg::COORD_W-1:0] rotated_y
);
   import prc_pkg::*;

   localparam logic signed [CW-1:0] UNIT_POS = CW'(ONE_Q30);
   localparam logic signed [SUM_W-1:0] ROUND_C = SUM_W'(1) <<< (FRAC - 1);
   localparam logic signed [RX_W-1:0] SAT_MAX =
      {{(RX_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
   localparam logic signed [RX_W-1:0] SAT_MIN =
      {{(RX_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic take1, take2, take3, take4;

   // stage 1: signed, clamped cosine and sine
   logic signed [CW-1:0] cos_raw, sin_raw, cos_cl, sin_cl;
   logic signed [UNIT_W-1:0] c1_ff, s1_ff;
   logic signed [DIFF_W-1:0] dx1_ff, dy1_ff;
   logic signed [COORD_W-1:0] cx1_ff, cy1_ff;

   // stage 2: products
   logic signed [PROD_W-1:0] pxc2_ff, pys2_ff, pxs2_ff, pyc2_ff;
   logic signed [COORD_W-1:0] cx2_ff, cy2_ff;

   // stage 3: rounded offsets
   logic signed [SUM_W-1:0] tx, ty;
   logic signed [TQ_W-1:0] qx3_ff, qy3_ff;
   logic signed [COORD_W-1:0] cx3_ff, cy3_ff;

   // stage 4: saturated result
   logic signed [RX_W-1:0] rx, ry;
   logic signed [COORD_W-1:0] rx_in, ry_in, rx4_ff, ry4_ff;

   assign take4 = !v4_ff || down_ready;
   assign take3 = !v3_ff || take4;
   assign take2 = !v2_ff || take3;
   assign take1 = !v1_ff || take2;
   assign up_ready = take1;

   always_comb begin
      cos_raw = up_lane.neg ? -up_lane.x : up_lane.x;
      sin_raw = up_lane.neg ? -up_lane.y : up_lane.y;
      if (cos_raw > UNIT_POS) begin
         cos_cl = UNIT_POS;
      end else if (cos_raw < -UNIT_POS) begin
         cos_cl = -UNIT_POS;
      end else begin
         cos_cl = cos_raw;
      end
      if (sin_raw > UNIT_POS) begin
         sin_cl = UNIT_POS;
      end else if (sin_raw < -UNIT_POS) begin
         sin_cl = -UNIT_POS;
      end else begin
         sin_cl = sin_raw;
      end
   end

   assign tx = SUM_W'(pxc2_ff) - SUM_W'(pys2_ff) + ROUND_C;
   assign ty = SUM_W'(pxs2_ff) + SUM_W'(pyc2_ff) + ROUND_C;

   always_comb begin
      rx = RX_W'(cx3_ff) + RX_W'(qx3_ff);
      ry = RX_W'(cy3_ff) + RX_W'(qy3_ff);
      if (rx > SAT_MAX) begin
         rx_in = SAT_MAX[COORD_W-1:0];
      end else if (rx < SAT_MIN) begin
         rx_in = SAT_MIN[COORD_W-1:0];
      end else begin
         rx_in = rx[COORD_W-1:0];
      end
      if (ry > SAT_MAX) begin
         ry_in = SAT_MAX[COORD_W-1:0];
      end else if (ry < SAT_MIN) begin
         ry_in = SAT_MIN[COORD_W-1:0];
      end else begin
         ry_in = ry[COORD_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (take1) v1_ff <= up_valid;
         if (take2) v2_ff <= v1_ff;
         if (take3) v3_ff <= v2_ff;
         if (take4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (take1) begin
         c1_ff <= cos_cl[UNIT_W-1:0];
         s1_ff <= sin_cl[UNIT_W-1:0];
         dx1_ff <= up_lane.dx;
         dy1_ff <= up_lane.dy;
         cx1_ff <= up_lane.cx;
         cy1_ff <= up_lane.cy;
      end
      if (take2) begin
         pxc2_ff <= PROD_W'(dx1_ff) * PROD_W'(c1_ff);
         pys2_ff <= PROD_W'(dy1_ff) * PROD_W'(s1_ff);
         pxs2_ff <= PROD_W'(dx1_ff) * PROD_W'(s1_ff);
         pyc2_ff <= PROD_W'(dy1_ff) * PROD_W'(c1_ff);
         cx2_ff <= cx1_ff;
         cy2_ff <= cy1_ff;
      end
      if (take3) begin
         qx3_ff <= $signed(tx[SUM_W-1:FRAC]);
         qy3_ff <= $signed(ty[SUM_W-1:FRAC]);
         cx3_ff <= cx2_ff;
         cy3_ff <= cy2_ff;
      end
      if (take4) begin
         rx4_ff <= rx_in;
         ry4_ff <= ry_in;
      end
   end

   assign down_valid = v4_ff;
   assign rotated_x = rx4_ff;
   assign rotated_y = ry4_ff;

endmodule

[hw/rtl/point_rotate_about_center_unit.sv]
// point_rotate_about_center_unit: top level; angle register on the csr port,
// entry pipe, chain of cordic cells, exit pipe; depends on prc_pkg, prc_if
// and the prc_front, prc_cordic_cell and prc_back modules

// Rotates each incoming point (point_x, point_y) about its own center
// (center_x, center_y) by the angle held in the rotate_angle register, all in
// signed q16.16, with results saturated to the 32-bit range. The block takes
// one item per clock while results are not held back on rsp_item, and returns
// one result per item, in order: four entry stages reduce the angle to
// [-90, 90] degrees and turn it into radians, ITERATIONS cordic cells produce
// cosine and sine (one micro-rotation per cell), and four exit stages
// multiply, round, re-add the center and saturate. Every stage has its own
// valid bit and collapses bubbles, so items keep entering while a finished
// result waits on rsp_item until every stage holds an item. rotate_angle
// (1/64 degree, positive is counter-clockwise, reset 5 degrees) sits at byte
// address 0 of the csr port; write it only while no item is in flight.
module point_rotate_about_center_unit #(
   parameter int ITERATIONS = prc_pkg::ITER_DEF
) (
   input  logic clock,
   input  logic reset,
   prc_req_if.sink req_item,
   prc_rsp_if.source rsp_item,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [prc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [prc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [prc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic csr_pready
);
   import prc_pkg::*;

   localparam logic signed [ANGLE_W-1:0] ANGLE_RESET = 16'sd320;
   // word index of the only register
   localparam logic REG_ROTATE_ANGLE = 1'b0;

   // config register
   logic signed [ANGLE_W-1:0] angle_ff;
   logic csr_write;
   logic csr_hit;

   // chain links: link k feeds cell k, link ITERATIONS feeds the exit pipe
   prc_lane_type lane [0:ITERATIONS];
   logic link_valid [0:ITERATIONS];
   logic link_ready [0:ITERATIONS];

   // apb: no wait states, words at 4-byte steps
   assign csr_pready = 1'b1;
   assign csr_hit = (csr_paddr[CSR_ADDR_W-1] == REG_ROTATE_ANGLE);
   assign csr_write = csr_psel && csr_penable && csr_pwrite && csr_hit;
   assign csr_prdata = csr_hit ? CSR_DATA_W'(angle_ff) : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         angle_ff <= ANGLE_RESET;
      end else if (csr_write) begin
         angle_ff <= csr_pwdata[ANGLE_W-1:0];
      end
   end

   // angle fold, radians conversion and point differences
   prc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .rotate_angle (angle_ff),
      .up_valid   (req_item.valid),
      .up_ready   (req_item.ready),
      .point_x    (req_item.point_x),
      .point_y    (req_item.point_y),
      .center_x   (req_item.center_x),
      .center_y   (req_item.center_y),
      .down_valid (link_valid[0]),
      .down_ready (link_ready[0]),
      .down_lane  (lane[0])
   );

   // one micro-rotation per cell, shift and arctangent fixed by position
   for (genvar k = 0; k < ITERATIONS; k++) begin : g_cell
      prc_cordic_cell #(
         .CELL_INDEX (k)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .up_valid   (link_valid[k]),
         .up_ready   (link_ready[k]),
         .up_lane    (lane[k]),
         .down_valid (link_valid[k+1]),
         .down_ready (link_ready[k+1]),
         .down_lane  (lane[k+1])
      );
   end

   // products, rounding, center re-add, saturation and the output register
   prc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (link_valid[ITERATIONS]),
      .up_ready   (link_ready[ITERATIONS]),
      .up_lane    (lane[ITERATIONS]),
      .down_valid (rsp_item.valid),
      .down_ready (rsp_item.ready),
      .rotated_x  (rsp_item.rotated_x),
      .rotated_y  (rsp_item.rotated_y)
   );

endmodule

[verif/point_rotate_about_center_unit_checker.sv]
// point_rotate_about_center_unit_checker: watches the point and result channels
// and the csr port, predicts every rotated point and compares results in order
// depends on prc_pkg and prc_if
module point_rotate_about_center_unit_checker #(
   parameter int ITERATIONS = prc_pkg::ITER_DEF,
   parameter logic [prc_pkg::CSR_ADDR_W-1:0] ANGLE_ADDR = '0
) (
   input  logic clock,
   input  logic reset,
   prc_req_if req_mon,
   prc_rsp_if rsp_mon,
   input  logic csr_psel,
   input  logic csr_penable,
   input  logic csr_pwrite,
   input  logic [prc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [prc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input  logic [prc_pkg::CSR_DATA_W-1:0] csr_prdata,
   input  logic csr_pready,
   output int mismatches,
   output int points_in_flight
);
   import prc_pkg::*;

   localparam longint TURN = 23040;
   localparam longint HALF_TURN = 11520;
   localparam longint QUARTER_TURN = 5760;
   localparam longint PI_Q30 = 64'sd3373259426;
   localparam longint ROUND_Q30 = 64'sd536870912;
   localparam logic signed [ANGLE_W-1:0] ANGLE_RESET = 16'sd320;

   typedef struct packed {
      logic signed [COORD_W-1:0] rotated_x;
      logic signed [COORD_W-1:0] rotated_y;
   } rotated_point_type;

   rotated_point_type rotated_due [$];
   logic signed [ANGLE_W-1:0] angle_copy;
   longint atan_q30 [32];
   int fail_total = 0;

   // atan(2^-i) in q2.30
   initial begin
      atan_q30 = '{843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
                   16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
                   131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256,
                   128, 64, 32, 16, 8, 4, 2, 1, 0};
   end

   function automatic longint clamp_unit(input longint v);
      if (v > ONE_Q30) return ONE_Q30;
      if (v < -ONE_Q30) return -ONE_Q30;
      return v;
   endfunction

   function automatic logic signed [COORD_W-1:0] clip_q16(input longint v);
      if (v > 64'sd2147483647) return 32'sh7fff_ffff;
      if (v < -64'sd2147483648) return 32'sh8000_0000;
      return COORD_W'(v);
   endfunction

   // cosine and sine of the angle, q2.30, by micro-rotations on the folded angle
   task automatic unit_vector(input logic signed [ANGLE_W-1:0] ang,
                              output longint cos_q30, output longint sin_q30);
      longint r, z, x, y, xs, ys, mag;
      logic flip;
      int i;
      r = (longint'(ang) + 2 * TURN) % TURN;
      flip = 1'b0;
      if (r >= HALF_TURN) r -= TURN;
      if (r > QUARTER_TURN) begin
         r -= HALF_TURN;
         flip = 1'b1;
      end else if (r < -QUARTER_TURN) begin
         r += HALF_TURN;
         flip = 1'b1;
      end
      mag = (r < 0) ? -r : r;
      z = (mag * PI_Q30 + QUARTER_TURN) / HALF_TURN;
      if (r < 0) z = -z;
      x = GAIN_Q30;
      y = 0;
      for (i = 0; i < ITERATIONS && i < 32; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (z >= 0) begin
            x -= ys;
            y += xs;
            z -= atan_q30[i];
         end else begin
            x += ys;
            y -= xs;
            z += atan_q30[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      cos_q30 = clamp_unit(x);
      sin_q30 = clamp_unit(y);
   endtask

   task automatic rotate_point(input logic signed [COORD_W-1:0] px, py, cx, cy,
                               input logic signed [ANGLE_W-1:0] ang,
                               output rotated_point_type res);
      longint c, s, dx, dy, tx, ty;
      unit_vector(ang, c, s);
      dx = longint'(px) - longint'(cx);
      dy = longint'(py) - longint'(cy);
      tx = dx * c - dy * s;
      ty = dx * s + dy * c;
      res.rotated_x = clip_q16(longint'(cx) + ((tx + ROUND_Q30) >>> FRAC));
      res.rotated_y = clip_q16(longint'(cy) + ((ty + ROUND_Q30) >>> FRAC));
   endtask

   always @(posedge clock) begin : watch
      rotated_point_type due;
      rotated_point_type fresh;
      if (reset) begin
         angle_copy = ANGLE_RESET;
         rotated_due.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pready && csr_paddr == ANGLE_ADDR) begin
            if (csr_pwrite) begin
               angle_copy = csr_pwdata[ANGLE_W-1:0];
            end else if (csr_prdata[ANGLE_W-1:0] !== angle_copy) begin
               $display("%0t rotate_angle read expected %h actual %h", $time,
                        angle_copy, csr_prdata[ANGLE_W-1:0]);
               fail_total++;
            end
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (rotated_due.size() == 0) begin
               $display("%0t unexpected item expected none actual %h %h", $time,
                        rsp_mon.rotated_x, rsp_mon.rotated_y);
               fail_total++;
            end else begin
               due = rotated_due.pop_front();
               if (rsp_mon.rotated_x !== due.rotated_x) begin
                  $display("%0t rotated_x expected %h actual %h", $time,
                           due.rotated_x, rsp_mon.rotated_x);
                  fail_total++;
               end
               if (rsp_mon.rotated_y !== due.rotated_y) begin
                  $display("%0t rotated_y expected %h actual %h", $time,
                           due.rotated_y, rsp_mon.rotated_y);
                  fail_total++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            rotate_point(req_mon.point_x, req_mon.point_y, req_mon.center_x,
                         req_mon.center_y, angle_copy, fresh);
            rotated_due.push_back(fresh);
         end
      end
      mismatches <= fail_total;
      points_in_flight <= rotated_due.size();
   end

endmodule

[verif/point_rotate_about_center_unit_tb.sv]
// point_rotate_about_center_unit_tb: drives points and angle settings into the
// rotation unit and gives the verdict; depends on prc_pkg, prc_if, the unit
// and point_rotate_about_center_unit_checker
module point_rotate_about_center_unit_tb;
   import prc_pkg::*;

   localparam int ITERATIONS = ITER_DEF;
   localparam logic [CSR_ADDR_W-1:0] ANGLE_ADDR = 3'd0;
   // byte address of a register slot that does not exist
   localparam logic [CSR_ADDR_W-1:0] SPARE_ADDR = 3'd4;
   localparam int PHASES = 16;
   localparam int PHASE_POINTS = 70;
   localparam int HOLD_PHASE = 2;
   localparam int HOLD_OFF_CYCLES = 160;
   localparam int SETTLE_CYCLES = ITERATIONS + 16;
   localparam int STALL_LIMIT = 4000;
   localparam logic signed [COORD_W-1:0] C_MAX = 32'sh7fff_ffff;
   localparam logic signed [COORD_W-1:0] C_MIN = 32'sh8000_0000;
   localparam logic signed [COORD_W-1:0] C_ONE = 32'sh0001_0000;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;
   int mismatches;
   int points_in_flight;
   int stall_count = 0;
   // handshake between stimulus and the result sink
   logic hold_off_req = 1'b0;
   logic quiet_tail = 1'b0;

   prc_req_if req_item();
   prc_rsp_if rsp_item();

   point_rotate_about_center_unit #(.ITERATIONS(ITERATIONS)) DUT (
      .clock(clock),
      .reset(reset),
      .req_item(req_item),
      .rsp_item(rsp_item),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   point_rotate_about_center_unit_checker #(
      .ITERATIONS(ITERATIONS),
      .ANGLE_ADDR(ANGLE_ADDR)
   ) rotation_check (
      .clock(clock),
      .reset(reset),
      .req_mon(req_item),
      .rsp_mon(rsp_item),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready),
      .mismatches(mismatches),
      .points_in_flight(points_in_flight)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // watchdog: any accepted item on either side restarts the count
   always @(posedge clock) begin
      if (reset || (req_item.valid && req_item.ready) || (rsp_item.valid && rsp_item.ready)) begin
         stall_count <= 0;
      end else if (stall_count >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end else begin
         stall_count <= stall_count + 1;
      end
   end

   // result sink: random stall bursts, one long hold-off on request, and a
   // stall-free tail once the last phase starts
   initial begin : result_sink
      rsp_item.ready = 1'b0;
      wait (!reset);
      forever begin
         @(negedge clock);
         if (hold_off_req) begin
            // long hold-off so the pipe fills up and back-pressures the input
            rsp_item.ready = 1'b0;
            repeat (HOLD_OFF_CYCLES - 1) @(negedge clock);
            hold_off_req = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 3) == 0) begin
            rsp_item.ready = 1'b0;
            repeat ($urandom_range(0, 16)) @(negedge clock);
         end else begin
            rsp_item.ready = 1'b1;
            repeat ($urandom_range(0, 30)) @(negedge clock);
         end
      end
   end

   // mostly full-range values, some small coordinates, some extremes
   function automatic logic signed [COORD_W-1:0] pick_coord();
      logic [COORD_W-1:0] r;
      r = $urandom;
      case ($urandom_range(0, 5))
         0: begin
            case (r[1:0])
               2'd0: return C_MAX;
               2'd1: return C_MIN;
               2'd2: return '0;
               default: return -1;
            endcase
         end
         1, 2: return {{10{r[21]}}, r[21:0]};
         default: return r;
      endcase
   endfunction

   // angle of each phase: zero, 30 degrees, full turns, the 16-bit extremes, fold
   // edges at +-90 degrees and just past, half turns, 270 degrees, random 16-bit values
   function automatic logic signed [ANGLE_W-1:0] angle_for_phase(input int p);
      case (p)
         0: return 16'sd0;
         1: return 16'sd23040;
         2: return 16'sd1920;
         3: return -16'sd23040;
         4: return 16'sd32767;
         5: return -16'sd32768;
         6: return 16'sd5760;
         7: return -16'sd5760;
         8: return 16'sd5761;
         9: return -16'sd5761;
         10: return 16'sd11520;
         11: return -16'sd11520;
         12: return 16'sd17280;
         default: return ANGLE_W'($urandom_range(0, 16'hffff));
      endcase
   endfunction

   // offer one point from the falling edge and hold it until it is taken
   task automatic offer_point(input logic signed [COORD_W-1:0] px, py, cx, cy);
      @(negedge clock);
      req_item.valid = 1'b1;
      req_item.point_x = px;
      req_item.point_y = py;
      req_item.center_x = cx;
      req_item.center_y = cy;
      @(posedge clock);
      while (!req_item.ready) @(posedge clock);
   endtask

   task automatic pause_points(input int cycles);
      @(negedge clock);
      req_item.valid = 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // stop offering and wait until every predicted result has come back
   task automatic drain_points();
      @(negedge clock);
      req_item.valid = 1'b0;
      while (points_in_flight != 0) @(negedge clock);
   endtask

   // one apb transfer: setup cycle, access cycle, then back to idle
   task automatic csr_access(input logic write, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite = write;
      csr_paddr = addr;
      csr_pwdata = data;
      @(negedge clock);
      csr_penable = 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
   endtask

   // write the angle, then read it back (the checker compares the read)
   task automatic set_angle(input logic signed [ANGLE_W-1:0] ang);
      csr_access(1'b1, ANGLE_ADDR, CSR_DATA_W'(ang));
      csr_access(1'b0, ANGLE_ADDR, '0);
   endtask

   initial begin : stimulus
      int phase;
      int n;
      int idle_odds;
      reset = 1'b1;
      req_item.valid = 1'b0;
      req_item.point_x = '0;
      req_item.point_y = '0;
      req_item.center_x = '0;
      req_item.center_y = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed points at the reset angle of 5 degrees, back to back
      offer_point('0, '0, '0, '0);
      offer_point(C_MAX, C_MAX, C_MAX, C_MAX);
      offer_point(C_MIN, C_MIN, C_MIN, C_MIN);
      // largest positive and negative differences on each axis
      offer_point(C_MAX, '0, C_MIN, '0);
      offer_point(C_MIN, '0, C_MAX, '0);
      offer_point('0, C_MAX, '0, C_MIN);
      offer_point('0, C_MIN, '0, C_MAX);
      // results pushed past the q16.16 range, high and low
      offer_point(C_MAX, C_MIN, C_MAX, C_MAX);
      offer_point(C_MIN, C_MAX, C_MIN, C_MIN);
      offer_point(C_MAX, C_MAX, C_MIN, C_MIN);
      offer_point(C_MIN, C_MIN, C_MAX, C_MAX);
      // unit vectors and small offsets about a shifted center
      offer_point(C_ONE, '0, '0, '0);
      offer_point('0, C_ONE, '0, '0);
      offer_point(32'sh0005_0000, 32'sh0003_0000, 32'sh0002_0000, 32'sh0001_0000);
      offer_point(-1, 1, 1, -1);
      offer_point(1, '0, '0, '0);
      // alternating bit patterns
      offer_point(32'sh5555_5555, 32'shaaaa_aaaa, 32'sh3333_3333, 32'shcccc_cccc);
      offer_point(32'shaaaa_aaaa, 32'sh5555_5555, 32'shcccc_cccc, 32'sh3333_3333);
      drain_points();

      // a write to an unmapped slot must leave the angle alone
      csr_access(1'b1, SPARE_ADDR, 32'h0000_1234);
      csr_access(1'b0, ANGLE_ADDR, '0);

      for (phase = 0; phase < PHASES; phase++) begin
         // the sender pauses here until every result is back, then reprograms
         drain_points();
         set_angle(angle_for_phase(phase));
         quiet_tail = (phase == PHASES - 1);
         if (phase == HOLD_PHASE) hold_off_req = 1'b1;
         idle_odds = (quiet_tail || phase == HOLD_PHASE) ? 0 : $urandom_range(0, 3);
         for (n = 0; n < PHASE_POINTS; n++) begin
            if (idle_odds != 0 && $urandom_range(1, 8) <= idle_odds)
               pause_points($urandom_range(1, 17));
            offer_point(pick_coord(), pick_coord(), pick_coord(), pick_coord());
         end
      end

      drain_points();
      // let any stray result show up before the verdict
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[files.f]
hw/rtl/prc_pkg.sv
hw/rtl/prc_if.sv
hw/rtl/prc_front.sv
hw/rtl/prc_cordic_cell.sv
hw/rtl/prc_back.sv
hw/rtl/point_rotate_about_center_unit.sv
verif/point_rotate_about_center_unit_checker.sv
verif/point_rotate_about_center_unit_tb.sv
